// ===== rtl/core/drc_pkg.sv =====
package drc_pkg;

  localparam int COORD_W    = 16;
  localparam int LIMIT_W    = 6;
  localparam int IDX_OUT_W  = 5;
  localparam int USED_OUT_W = 6;
  localparam int ACTION_W   = 3;

  typedef struct packed {
    logic signed [COORD_W-1:0] bottom;
    logic signed [COORD_W-1:0] right;
    logic signed [COORD_W-1:0] top;
    logic signed [COORD_W-1:0] left;
  } rect_t;

  localparam int RECT_W = $bits(rect_t);

  typedef enum logic [ACTION_W-1:0] {
    ACT_COVERED  = 3'd0,
    ACT_MERGED   = 3'd1,
    ACT_APPENDED = 3'd2,
    ACT_FULL     = 3'd3,
    ACT_CLEARED  = 3'd4
  } action_t;

  typedef struct packed {
    logic covers;
    logic overlaps;
  } cmp_t;

  typedef enum logic [5:0] {
    ST_IDLE     = 6'b000001,
    ST_SCAN     = 6'b000010,
    ST_DECIDE   = 6'b000100,
    ST_FULL_RD  = 6'b001000,
    ST_FULL_MRG = 6'b010000,
    ST_CLEAR    = 6'b100000
  } state_t;

endpackage

// ===== rtl/core/drc_ram.sv =====
module drc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/drc_rect_unit.sv =====
module drc_rect_unit (
  input  drc_pkg::rect_t slot,
  input  drc_pkg::rect_t nb,
  output drc_pkg::cmp_t  flags,
  output drc_pkg::rect_t merged
);

  logic l_le, t_le, r_ge, b_ge;

  assign l_le = $signed(slot.left)   <= $signed(nb.left);
  assign t_le = $signed(slot.top)    <= $signed(nb.top);
  assign r_ge = $signed(slot.right)  >= $signed(nb.right);
  assign b_ge = $signed(slot.bottom) >= $signed(nb.bottom);

  assign flags.covers   = l_le && r_ge && t_le && b_ge;
  assign flags.overlaps = !(($signed(nb.right)  < $signed(slot.left)) ||
                            ($signed(nb.bottom) < $signed(slot.top))  ||
                            ($signed(nb.left)   > $signed(slot.right)) ||
                            ($signed(nb.top)    > $signed(slot.bottom)));

  assign merged.left   = l_le ? slot.left   : nb.left;
  assign merged.top    = t_le ? slot.top    : nb.top;
  assign merged.right  = r_ge ? slot.right  : nb.right;
  assign merged.bottom = b_ge ? slot.bottom : nb.bottom;

endmodule

// ===== rtl/core/dirty_rect_coalescer_unit.sv =====
// Coalesces redraw rectangles into a table of up to MAX_SLOTS slots held in a
// single-port-write RAM with registered read. A clear item goes to the clear
// state once accepted and finishes when the output register can take its
// result. A schedule item walks the used slots through one shared compare and
// merge unit, one slot per cycle, and finishes at the first slot that covers or
// overlaps the box; with no match it appends the box, or when the table is
// full merges it into the last allowed slot. The input is not ready while an
// item is at work; a result waits in the output register while the next item
// is accepted.
module dirty_rect_coalescer_unit #(
  parameter int MAX_SLOTS = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [drc_pkg::LIMIT_W-1:0]   cfg_wdata,    // slot_limit
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [63:0]                   s_tdata,      // left, top, right, bottom
  input  logic                          s_tuser,      // req_type
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // slot_index, slot_left, slot_top, slot_right, slot_bottom, slots_used, zero fill
  output logic [79:0]                   m_tdata,
  output logic [drc_pkg::ACTION_W-1:0]  m_tuser       // action
);

  localparam int IW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int CW = $clog2(MAX_SLOTS + 1);

  drc_pkg::state_t state, state_next;
  logic [IW-1:0]   idx, idx_next;
  logic [CW-1:0]   used, used_next;
  logic [drc_pkg::LIMIT_W-1:0] slot_limit;
  logic [CW-1:0]   lim;
  drc_pkg::rect_t  nb;

  logic            ram_we, ram_re;
  logic [IW-1:0]   ram_waddr, ram_raddr;
  drc_pkg::rect_t  ram_wdata, ram_rdata;

  drc_pkg::cmp_t   flags;
  drc_pkg::rect_t  merged;

  logic            can_emit, emit, last_slot;
  drc_pkg::action_t emit_action;
  logic [IW-1:0]   emit_idx;
  drc_pkg::rect_t  emit_rect;

  drc_pkg::action_t out_action;
  logic [drc_pkg::IDX_OUT_W-1:0]  out_idx;
  logic [drc_pkg::USED_OUT_W-1:0] out_used;
  drc_pkg::rect_t  out_rect;

  drc_ram #(
    .WIDTH(drc_pkg::RECT_W),
    .DEPTH(MAX_SLOTS)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  drc_rect_unit u_rect (
    .slot  (ram_rdata),
    .nb    (nb),
    .flags (flags),
    .merged(merged)
  );

  always_comb begin
    if (slot_limit == '0) begin
      lim = CW'(1);
    end else if (32'(slot_limit) > MAX_SLOTS) begin
      lim = CW'(MAX_SLOTS);
    end else begin
      lim = CW'(slot_limit);
    end
  end

  assign s_tready  = (state == drc_pkg::ST_IDLE);
  assign can_emit  = !m_tvalid || m_tready;
  assign last_slot = ((IW + 1)'(idx) + (IW + 1)'(1)) >= (IW + 1)'(used);

  always_comb begin
    state_next  = state;
    idx_next    = idx;
    used_next   = used;
    ram_we      = 1'b0;
    ram_waddr   = idx;
    ram_wdata   = merged;
    ram_re      = 1'b0;
    ram_raddr   = IW'((IW + 1)'(idx) + (IW + 1)'(1));
    emit        = 1'b0;
    emit_action = drc_pkg::ACT_COVERED;
    emit_idx    = idx;
    emit_rect   = merged;
    unique case (state)
      drc_pkg::ST_IDLE: begin
        ram_raddr = '0;
        if (s_tvalid) begin
          ram_re   = 1'b1;
          idx_next = '0;
          if (s_tuser) begin
            state_next = drc_pkg::ST_CLEAR;
          end else if (used == '0) begin
            state_next = drc_pkg::ST_DECIDE;
          end else begin
            state_next = drc_pkg::ST_SCAN;
          end
        end
      end
      drc_pkg::ST_SCAN: begin
        if (flags.covers) begin
          if (can_emit) begin
            emit        = 1'b1;
            emit_action = drc_pkg::ACT_COVERED;
            emit_rect   = ram_rdata;
            state_next  = drc_pkg::ST_IDLE;
          end
        end else if (flags.overlaps) begin
          if (can_emit) begin
            ram_we      = 1'b1;
            emit        = 1'b1;
            emit_action = drc_pkg::ACT_MERGED;
            state_next  = drc_pkg::ST_IDLE;
          end
        end else if (last_slot) begin
          state_next = drc_pkg::ST_DECIDE;
        end else begin
          ram_re   = 1'b1;
          idx_next = IW'((IW + 1)'(idx) + (IW + 1)'(1));
        end
      end
      drc_pkg::ST_DECIDE: begin
        if (used < lim) begin
          if (can_emit) begin
            ram_we      = 1'b1;
            ram_waddr   = IW'(used);
            ram_wdata   = nb;
            used_next   = used + CW'(1);
            emit        = 1'b1;
            emit_action = drc_pkg::ACT_APPENDED;
            emit_idx    = IW'(used);
            emit_rect   = nb;
            state_next  = drc_pkg::ST_IDLE;
          end
        end else begin
          idx_next   = IW'(lim - CW'(1));
          state_next = drc_pkg::ST_FULL_RD;
        end
      end
      drc_pkg::ST_FULL_RD: begin
        ram_raddr  = idx;
        ram_re     = 1'b1;
        state_next = drc_pkg::ST_FULL_MRG;
      end
      drc_pkg::ST_FULL_MRG: begin
        if (can_emit) begin
          ram_we      = 1'b1;
          emit        = 1'b1;
          emit_action = drc_pkg::ACT_FULL;
          state_next  = drc_pkg::ST_IDLE;
        end
      end
      drc_pkg::ST_CLEAR: begin
        if (can_emit) begin
          used_next   = '0;
          emit        = 1'b1;
          emit_action = drc_pkg::ACT_CLEARED;
          emit_idx    = '0;
          emit_rect   = '0;
          state_next  = drc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = drc_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= drc_pkg::ST_IDLE;
      used       <= '0;
      idx        <= '0;
      slot_limit <= drc_pkg::LIMIT_W'(32);
      m_tvalid   <= 1'b0;
    end else begin
      state <= state_next;
      used  <= used_next;
      idx   <= idx_next;
      if (cfg_we) begin
        slot_limit <= cfg_wdata;
      end
      if (emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      nb <= drc_pkg::rect_t'(s_tdata);
    end
    if (emit) begin
      out_action <= emit_action;
      out_idx    <= drc_pkg::IDX_OUT_W'(emit_idx);
      out_rect   <= emit_rect;
      out_used   <= drc_pkg::USED_OUT_W'(used_next);
    end
  end

  assign m_tuser = out_action;
  assign m_tdata = {5'b0, out_used, out_rect, out_idx};

  a_write_only_on_result: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> emit)
    else $error("slot table written without a result");

  a_result_not_overwritten: assert property (@(posedge clk) disable iff (rst)
    emit |-> (!m_tvalid || m_tready))
    else $error("pending result overwritten");

  a_full_merge_in_use: assert property (@(posedge clk) disable iff (rst)
    (state == drc_pkg::ST_FULL_MRG) |-> ((IW + 1)'(idx) < (IW + 1)'(used)))
    else $error("full-table merge targets an unused slot");

  a_append_counts: assert property (@(posedge clk) disable iff (rst)
    (emit && emit_action == drc_pkg::ACT_APPENDED) |=> (used == $past(used) + CW'(1)))
    else $error("append did not advance the used count");

endmodule

// ===== dv/dirty_rect_coalescer_unit_test.sv =====
module dirty_rect_coalescer_unit_test;
  import drc_pkg::*;

  localparam int TABLE_DEPTH = 32;
  localparam int CYCLE_LIMIT = 500000;
  localparam int LONG_HOLD = 400;

  typedef struct {
    logic  clear;
    rect_t box;
  } damage_item_t;

  typedef struct packed {
    action_t                 action;
    logic [IDX_OUT_W-1:0]    idx;
    rect_t                   rect;
    logic [USED_OUT_W-1:0]   used;
  } slot_report_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [LIMIT_W-1:0]   cfg_wdata = '0;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [63:0]          s_tdata = '0;
  logic                 s_tuser = 1'b0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [79:0]          m_tdata;
  logic [ACTION_W-1:0]  m_tuser;

  dirty_rect_coalescer_unit #(.MAX_SLOTS(TABLE_DEPTH)) dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser)
  );

  always #1 clk = ~clk;

  damage_item_t pending_items[$];
  slot_report_t expected_reports[$];
  rect_t        recent_boxes[$];

  rect_t        table_rects[TABLE_DEPTH];
  int           table_used = 0;
  int           table_limit = 32;

  int           mismatches = 0;
  bit           in_taken = 1'b0;
  bit           calm = 1'b0;
  int           src_gap = 0;
  int           sink_gap = 0;
  int           hold_asked = 0;
  int           hold_seen = 0;
  int           hold_left = 0;
  damage_item_t next_item;
  slot_report_t want_rep;

  function automatic rect_t grow_rect(rect_t s, rect_t n);
    rect_t g;
    g.left   = (n.left < s.left) ? n.left : s.left;
    g.top    = (n.top < s.top) ? n.top : s.top;
    g.right  = (n.right > s.right) ? n.right : s.right;
    g.bottom = (n.bottom > s.bottom) ? n.bottom : s.bottom;
    return g;
  endfunction

  function automatic slot_report_t coalesce_step(damage_item_t it);
    slot_report_t r;
    rect_t        s;
    rect_t        nb;
    int           lim;
    r = '0;
    nb = it.box;
    if (it.clear) begin
      table_used = 0;
      r.action = ACT_CLEARED;
      return r;
    end
    for (int i = 0; i < table_used && i < TABLE_DEPTH; i++) begin
      s = table_rects[i];
      if (s.left <= nb.left && s.right >= nb.right && s.top <= nb.top &&
          s.bottom >= nb.bottom) begin
        r.action = ACT_COVERED;
        r.idx = i[IDX_OUT_W-1:0];
        r.rect = s;
        r.used = table_used[USED_OUT_W-1:0];
        return r;
      end
      if (!(nb.right < s.left || nb.bottom < s.top || nb.left > s.right ||
            nb.top > s.bottom)) begin
        table_rects[i] = grow_rect(s, nb);
        r.action = ACT_MERGED;
        r.idx = i[IDX_OUT_W-1:0];
        r.rect = table_rects[i];
        r.used = table_used[USED_OUT_W-1:0];
        return r;
      end
    end
    lim = (table_limit < 1) ? 1 : ((table_limit > TABLE_DEPTH) ? TABLE_DEPTH : table_limit);
    if (table_used < lim) begin
      table_rects[table_used] = nb;
      r.action = ACT_APPENDED;
      r.idx = table_used[IDX_OUT_W-1:0];
      r.rect = nb;
      table_used++;
      r.used = table_used[USED_OUT_W-1:0];
      return r;
    end
    table_rects[lim-1] = grow_rect(table_rects[lim-1], nb);
    r.action = ACT_FULL;
    r.idx = 5'(lim - 1);
    r.rect = table_rects[lim-1];
    r.used = table_used[USED_OUT_W-1:0];
    return r;
  endfunction

  task automatic check_field(input string what, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0h actual %0h", $time, what, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      table_used = 0;
      table_limit = 32;
      in_taken = 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_reports.size() == 0) begin
          $display("%0t: result item expected none actual %0h/%0h", $time, m_tuser, m_tdata);
          mismatches++;
        end else begin
          want_rep = expected_reports.pop_front();
          check_field("action", want_rep.action, m_tuser);
          check_field("slot_index", want_rep.idx, m_tdata[4:0]);
          check_field("slot_left", $unsigned(want_rep.rect.left), m_tdata[20:5]);
          check_field("slot_top", $unsigned(want_rep.rect.top), m_tdata[36:21]);
          check_field("slot_right", $unsigned(want_rep.rect.right), m_tdata[52:37]);
          check_field("slot_bottom", $unsigned(want_rep.rect.bottom), m_tdata[68:53]);
          check_field("slots_used", want_rep.used, m_tdata[74:69]);
          check_field("zero fill", 0, m_tdata[79:75]);
        end
      end
      if (s_tvalid && s_tready) begin
        next_item.clear = s_tuser;
        next_item.box = rect_t'(s_tdata);
        expected_reports.push_back(coalesce_step(next_item));
      end
      in_taken = s_tvalid && s_tready;
      if (cfg_we) table_limit = cfg_wdata;
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || in_taken) begin
      if (src_gap > 0) begin
        src_gap--;
        s_tvalid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        next_item = pending_items.pop_front();
        s_tdata <= next_item.box;
        s_tuser <= next_item.clear;
        s_tvalid <= 1'b1;
        if (!calm && $urandom_range(0, 5) == 0) src_gap = $urandom_range(1, 3);
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (hold_seen != hold_asked) begin
      hold_seen++;
      hold_left = LONG_HOLD;
      m_tready <= 1'b0;
    end else if (sink_gap > 0) begin
      sink_gap--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
      if (!calm && $urandom_range(0, 5) == 0) sink_gap = $urandom_range(1, 3);
    end
  end

  task automatic push_box(input int l, input int t, input int r, input int b);
    damage_item_t it;
    it.clear = 1'b0;
    it.box.left = 16'(l);
    it.box.top = 16'(t);
    it.box.right = 16'(r);
    it.box.bottom = 16'(b);
    pending_items.push_back(it);
    recent_boxes.push_back(it.box);
    if (recent_boxes.size() > 8) void'(recent_boxes.pop_front());
  endtask

  task automatic push_clear();
    damage_item_t it;
    it.clear = 1'b1;
    it.box = rect_t'({$urandom, $urandom});
    pending_items.push_back(it);
  endtask

  task automatic push_random_item(input int origin_x, input int origin_y, input int area,
                                  input int span);
    int    mode;
    int    x;
    int    y;
    int    w;
    int    h;
    int    a;
    rect_t pick;
    mode = $urandom_range(0, 99);
    if (mode < 4) begin
      push_clear();
    end else if (mode < 14) begin
      push_box($signed(16'($urandom)), $signed(16'($urandom)), $signed(16'($urandom)),
               $signed(16'($urandom)));
    end else if (mode < 34 && recent_boxes.size() > 0) begin
      pick = recent_boxes[$urandom_range(0, recent_boxes.size() - 1)];
      if (pick.left <= pick.right && pick.top <= pick.bottom) begin
        w = int'(pick.right) - int'(pick.left);
        h = int'(pick.bottom) - int'(pick.top);
        a = $urandom_range(0, w);
        x = int'(pick.left) + a;
        w = $urandom_range(0, w - a);
        a = $urandom_range(0, h);
        y = int'(pick.top) + a;
        h = $urandom_range(0, h - a);
        push_box(x, y, x + w, y + h);
      end else begin
        push_box(pick.right, pick.bottom, pick.left, pick.top);
      end
    end else begin
      x = origin_x + $urandom_range(0, area);
      y = origin_y + $urandom_range(0, area);
      w = $urandom_range(0, span);
      h = $urandom_range(0, span);
      if ($urandom_range(0, 19) == 0) push_box(x + w, y + h, x, y);
      else push_box(x, y, x + w, y + h);
    end
  endtask

  task automatic wait_idle();
    @(posedge clk);
    while (pending_items.size() > 0 || s_tvalid || expected_reports.size() > 0)
      @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_limit(input int value);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_wdata <= value[LIMIT_W-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  int phase_limits[10] = '{32, 5, 1, 63, 0, 2, 9, 32, 17, 32};
  int origin_x;
  int origin_y;
  int area;
  int span;

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    push_clear();
    push_box(0, 0, 10, 10);
    push_box(2, 2, 5, 5);
    push_box(10, 10, 20, 20);
    push_box(100, 100, 110, 110);
    push_box(50, 50, 40, 40);
    push_box(-32768, -32768, -32768, -32768);
    push_box(32767, 32767, 32767, 32767);
    push_box(100, 111, 110, 120);
    set_limit(1);
    push_box(1000, 1000, 1001, 1001);
    push_box(5, 5, 6, 6);
    set_limit(0);
    push_box(-500, -500, -400, -400);
    push_clear();
    set_limit(2);
    push_box(0, 0, 1, 1);
    push_box(10, 10, 11, 11);
    push_box(20, 20, 21, 21);
    push_box(30, 30, 30, 30);
    set_limit(63);
    push_clear();
    push_box(-32768, -32768, 32767, 32767);
    push_box(-32768, 32767, 32767, -32768);
    push_box(-1, -1, 0, 0);

    for (int p = 0; p < 10; p++) begin
      if (p == 6) set_limit($urandom_range(3, 31));
      else set_limit(phase_limits[p]);
      if (p == 9) calm = 1'b1;
      origin_x = $urandom_range(0, 58000) - 30000;
      origin_y = $urandom_range(0, 58000) - 30000;
      area = (phase_limits[p] >= 17) ? $urandom_range(2000, 3000) : $urandom_range(100, 1500);
      span = $urandom_range(0, 300);
      for (int k = 0; k < 112; k++) push_random_item(origin_x, origin_y, area, span);
      if (p == 2) hold_asked++;
    end

    wait_idle();
    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Mismatches found");
    $finish;
  end

endmodule
